/* rtl/core/bmpf_pkg.sv */
// ============================================================================
// Bounded max-plus filter package
// Shared widths, register indexes and controller/datapath handshake types.
// ============================================================================
package bmpf_pkg;

   // Defaults for the top level parameters.
   localparam int S_DEFAULT       = 4;
   localparam int MAX_LEN_DEFAULT = 1024;

   // Field widths.
   localparam int SAMPLE_W = 24;   // Q12.12 score sample
   localparam int VALUE_W  = 25;   // Q13.12 filtered sum
   localparam int COST_W   = 16;   // Q4.12 cost entry
   localparam int POS_W    = 10;   // position within a line
   localparam int CSR_W    = 64;   // configuration data width

   // Cost table: three 64-bit words of four entries each.
   localparam int NUM_COST   = 12;
   localparam int COST_IDX_W = $clog2(NUM_COST);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_COST_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COST_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COST_HIGH = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // take the input beat
      logic start;    // set up the neighbour scan for the current position
      logic step;     // add and compare one neighbour
      logic emit;     // load the result register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_result;   // the offered beat produces at least one result
      logic scan_done;    // the neighbour being scanned is the last one
      logic more;         // more positions of this beat remain to flush
      logic out_free;     // the result register can be loaded this cycle
   } dp_status_type;

endpackage

/* rtl/core/bmpf_if.sv */
// ============================================================================
// Bounded max-plus filter channel interfaces
// Valid/ready channels for sample beats and result beats.
// ============================================================================
interface bmpf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [bmpf_pkg::SAMPLE_W-1:0] sample;
   logic                                end_of_line;

   modport source (output valid, output sample, output end_of_line, input ready);
   modport sink   (input valid, input sample, input end_of_line, output ready);
endinterface

interface bmpf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bmpf_pkg::VALUE_W-1:0] filtered_value;
   logic [bmpf_pkg::POS_W-1:0]          best_position;
   logic                               last_of_line;

   modport source (output valid, output filtered_value, output best_position,
                   output last_of_line, input ready);
   modport sink   (input valid, input filtered_value, input best_position,
                   input last_of_line, output ready);
endinterface

/* rtl/core/bmpf_ctrl.sv */
// ============================================================================
// Bounded max-plus filter controller
// Sequences beat intake, neighbour scans and result loads.
// ============================================================================
module bmpf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bmpf_pkg::dp_status_type status,
   output bmpf_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.has_result) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.more ? ST_START : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/bmpf_datapath.sv */
// ============================================================================
// Bounded max-plus filter datapath
// Sample window, line positions, cost table, shared adder-comparator and
// the result register.
// ============================================================================
module bmpf_datapath #(
   parameter int S       = bmpf_pkg::S_DEFAULT,
   parameter int MAX_LEN = bmpf_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bmpf_pkg::dp_cmd_type                  cmd,
   output bmpf_pkg::dp_status_type               status,
   input  logic signed [bmpf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_end_of_line,
   input  logic                                  csr_we,
   input  logic [bmpf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bmpf_pkg::CSR_W-1:0]            csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bmpf_pkg::VALUE_W-1:0]   rsp_filtered_value,
   output logic [bmpf_pkg::POS_W-1:0]            rsp_best_position,
   output logic                                  rsp_last_of_line
);

   localparam int POS_W    = bmpf_pkg::POS_W;
   localparam int SAMPLE_W = bmpf_pkg::SAMPLE_W;
   localparam int VALUE_W  = bmpf_pkg::VALUE_W;
   localparam int COST_W   = bmpf_pkg::COST_W;
   localparam int WIN      = 2 * S + 1;
   localparam int SLOT_W   = $clog2(WIN);
   localparam logic [POS_W-1:0]  S_POS    = POS_W'(S);
   localparam logic [POS_W-1:0]  LAST_POS = POS_W'(MAX_LEN - 1);
   localparam logic [SLOT_W-1:0] WIN_LAST = SLOT_W'(WIN - 1);
   localparam logic [SLOT_W:0]   WIN_EXT  = (SLOT_W + 1)'(WIN);

   // Configuration.
   logic [bmpf_pkg::CSR_W-1:0] cost_low_ff, cost_mid_ff, cost_high_ff;
   logic [3*bmpf_pkg::CSR_W-1:0] cost_all;
   logic signed [COST_W-1:0] cost_tab [bmpf_pkg::NUM_COST];

   // Window and positions.
   logic signed [SAMPLE_W-1:0] win_ff [WIN];
   logic [POS_W-1:0]  wr_pos_ff, emit_pos_ff, cur_p_ff, i_ff, j_ff, stop_ff;
   logic [SLOT_W-1:0] wr_slot_ff, cur_slot_ff;
   logic              final_ff;

   // Scan accumulator and result register.
   logic signed [VALUE_W-1:0] best_ff;
   logic [POS_W-1:0]          best_j_ff;
   logic                      have_ff;
   logic                      out_valid_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic [POS_W-1:0]          out_pos_ff;
   logic                      out_last_ff;

   // Combinational helpers.
   logic                      is_final_in;
   logic [POS_W:0]            hi_ext;
   logic [POS_W-1:0]          back_dist, k_pos;
   logic [SLOT_W:0]           slot_ext, dist_ext, slot_wide;
   logic [SLOT_W-1:0]         rd_slot;
   logic signed [SAMPLE_W-1:0] rd_sample;
   logic signed [COST_W-1:0]  rd_cost;
   logic signed [VALUE_W-1:0] sum;

   assign cost_all = {cost_high_ff, cost_mid_ff, cost_low_ff};

   always_comb begin
      for (int e = 0; e < bmpf_pkg::NUM_COST; e++) begin
         cost_tab[e] = cost_all[e*COST_W +: COST_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_low_ff  <= '0;
         cost_mid_ff  <= '0;
         cost_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bmpf_pkg::CSR_COST_LOW:  cost_low_ff  <= csr_wdata;
            bmpf_pkg::CSR_COST_MID:  cost_mid_ff  <= csr_wdata;
            bmpf_pkg::CSR_COST_HIGH: cost_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A line ends on its marked sample or on the last position it can hold.
   assign is_final_in = req_end_of_line || (wr_pos_ff == LAST_POS);

   // Window slot of neighbour j: step back from the slot of the newest sample.
   assign back_dist = cur_p_ff - j_ff;
   assign slot_ext  = {1'b0, cur_slot_ff};
   assign dist_ext  = {1'b0, back_dist[SLOT_W-1:0]};
   assign slot_wide = (slot_ext >= dist_ext) ? (slot_ext - dist_ext)
                                             : (slot_ext + WIN_EXT - dist_ext);
   assign rd_slot   = slot_wide[SLOT_W-1:0];
   assign rd_sample = win_ff[rd_slot];

   // Cost entry i - j + S.
   assign k_pos   = i_ff + S_POS - j_ff;
   assign rd_cost = cost_tab[k_pos[bmpf_pkg::COST_IDX_W-1:0]];
   assign sum     = {rd_sample[SAMPLE_W-1], rd_sample}
                  + {{(VALUE_W - COST_W){rd_cost[COST_W-1]}}, rd_cost};

   assign hi_ext = {1'b0, i_ff} + {1'b0, S_POS};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         win_ff[wr_slot_ff] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff   <= '0;
         emit_pos_ff <= '0;
         wr_slot_ff  <= '0;
      end else if (cmd.accept) begin
         if (is_final_in) begin
            wr_pos_ff   <= '0;
            emit_pos_ff <= '0;
            wr_slot_ff  <= '0;
         end else begin
            wr_pos_ff  <= wr_pos_ff + 1'b1;
            wr_slot_ff <= (wr_slot_ff == WIN_LAST) ? '0 : wr_slot_ff + 1'b1;
            if (wr_pos_ff >= S_POS) begin
               emit_pos_ff <= wr_pos_ff - S_POS + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_p_ff    <= wr_pos_ff;
         cur_slot_ff <= wr_slot_ff;
         final_ff    <= is_final_in;
         i_ff        <= is_final_in ? emit_pos_ff : wr_pos_ff - S_POS;
      end else if (cmd.emit && status.more) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.start) begin
         j_ff    <= (i_ff >= S_POS) ? i_ff - S_POS : '0;
         stop_ff <= (hi_ext < {1'b0, cur_p_ff}) ? hi_ext[POS_W-1:0] : cur_p_ff;
      end else if (cmd.step) begin
         j_ff <= j_ff + 1'b1;
      end
   end

   // Shared adder-comparator; a strict compare keeps the earliest position.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         have_ff <= 1'b0;
      end else if (cmd.step) begin
         have_ff <= 1'b1;
         if (!have_ff || (sum > best_ff)) begin
            best_ff   <= sum;
            best_j_ff <= j_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_value_ff <= best_ff;
         out_pos_ff   <= best_j_ff;
         out_last_ff  <= final_ff && (i_ff == cur_p_ff);
      end
   end

   assign status.has_result = is_final_in || (wr_pos_ff >= S_POS);
   assign status.scan_done  = (j_ff == stop_ff);
   assign status.more       = final_ff && (i_ff != cur_p_ff);
   assign status.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid          = out_valid_ff;
   assign rsp_filtered_value = out_value_ff;
   assign rsp_best_position  = out_pos_ff;
   assign rsp_last_of_line   = out_last_ff;

   // The result register is never overwritten while it still holds a beat.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_ready))
      else $error("result register loaded while occupied");

   // The scan never reaches past the newest sample of the line.
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (j_ff <= cur_p_ff))
      else $error("neighbour scan ran past the newest sample");

   // The next result position never passes the next sample position.
   assert property (@(posedge clock) disable iff (reset)
      emit_pos_ff <= wr_pos_ff)
      else $error("emit position ahead of write position");

   // The end of a line restarts both positions.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && is_final_in) |=> (wr_pos_ff == '0 && emit_pos_ff == '0))
      else $error("positions not cleared at end of line");

endmodule

/* rtl/core/bounded_max_plus_filter_1d.sv */
// ============================================================================
// Bounded max-plus filter, one dimension
// For each position of a line of Q12.12 scores, the maximum of a neighbour
// sample plus a configured Q4.12 cost, with the position of that neighbour.
// ============================================================================
//
//   Channel  Direction  Handshake          Payload
//   req_     in         valid/ready        sample, end_of_line
//   rsp_     out        valid/ready        filtered_value, best_position,
//                                          last_of_line
//   csr_     in         write enable only  csr_index, csr_wdata
//
// The first result of a sample beat goes through intake, scan setup, one
// neighbour step per neighbour of its position (2*S + 1 inside the line, fewer
// near its ends) and the result load; the single shared adder-comparator
// looks at one neighbour per cycle. Each further result that the end-of-line
// beat flushes, up to S + 1 in all, takes another scan setup, its neighbour
// steps and a result load. A beat with no result is only taken in. Reset is
// synchronous and clears the positions, the cost registers and the valid
// flag of the result register. A stalled result holds in the output register;
// the next sample beat is taken while it waits, and the block stops only when
// a new result finds that register still full.
//
module bounded_max_plus_filter_1d #(
   parameter int S       = bmpf_pkg::S_DEFAULT,
   parameter int MAX_LEN = bmpf_pkg::MAX_LEN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   bmpf_req_if.sink                        req_chan,
   bmpf_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [bmpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmpf_pkg::CSR_W-1:0]      csr_wdata
);

   // Commands and status between the controller and the datapath.
   bmpf_pkg::dp_cmd_type    cmd;
   bmpf_pkg::dp_status_type status;
   logic                    req_ready;

   assign req_chan.ready = req_ready;

   // The controller walks each beat through intake, one scan per result
   // position, and the load of the result register.
   bmpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the last 2*S + 1 samples of the line, the write and
   // emit positions, the cost words and the running maximum.
   bmpf_datapath #(
      .S       (S),
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sample         (req_chan.sample),
      .req_end_of_line    (req_chan.end_of_line),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_filtered_value (rsp_chan.filtered_value),
      .rsp_best_position  (rsp_chan.best_position),
      .rsp_last_of_line   (rsp_chan.last_of_line)
   );

endmodule
